// ----- hw/rtl/omx_pkg.sv -----
// ----------------------------------------------------------------------------
// omx_pkg
// Shared widths and types of the four wheel omni mixer.
// ----------------------------------------------------------------------------
package omx_pkg;

   localparam int DIN_W         = 10;
   localparam int WHEEL_W       = 9;
   localparam int WHEELS        = 4;
   localparam int SUM_W         = 12;
   localparam int MAG_W         = 11;
   localparam int LIM_W         = 16;
   localparam int DIV_BITS      = 3;
   localparam int QUEUE_DEPTH   = 4;
   localparam int OUT_LIMIT_DEF = 255;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   typedef struct packed {
      logic [WHEELS-1:0][SUM_W-1:0] raw;
      logic [MAG_W-1:0]             mag;
      logic                         scaled;
   } omx_item_type;

endpackage

// ----- hw/rtl/omx_front.sv -----
// ----------------------------------------------------------------------------
// omx_front
// Mixes one drive request into four raw wheel values and classifies it.
// ----------------------------------------------------------------------------
module omx_front #(
   parameter int OUT_LIMIT = omx_pkg::OUT_LIMIT_DEF
) (
   input  logic signed [omx_pkg::DIN_W-1:0] drive_forward,
   input  logic signed [omx_pkg::DIN_W-1:0] drive_sideways,
   input  logic signed [omx_pkg::DIN_W-1:0] drive_rotate,
   output omx_pkg::omx_item_type            item
);
   import omx_pkg::*;

   localparam logic [LIM_W-1:0] LIMIT_V = LIM_W'(OUT_LIMIT);

   logic signed [SUM_W-1:0] fx;
   logic signed [SUM_W-1:0] sx;
   logic signed [SUM_W-1:0] rx;
   logic signed [SUM_W-1:0] w [WHEELS];
   logic [MAG_W-1:0]        m [WHEELS];
   logic [MAG_W-1:0]        max_a;
   logic [MAG_W-1:0]        max_b;
   logic [MAG_W-1:0]        max_all;
   logic                    over_limit;

   assign fx = SUM_W'(drive_forward);
   assign sx = SUM_W'(drive_sideways);
   assign rx = SUM_W'(drive_rotate);

   assign w[0] =  fx + sx - rx;
   assign w[1] =  fx - sx - rx;
   assign w[2] = -fx - sx - rx;
   assign w[3] = -fx + sx - rx;

   always_comb begin
      for (int i = 0; i < WHEELS; i++) begin
         m[i] = w[i][SUM_W-1] ? MAG_W'(-w[i]) : MAG_W'(w[i]);
      end
   end

   assign max_a   = (m[0] > m[1]) ? m[0] : m[1];
   assign max_b   = (m[2] > m[3]) ? m[2] : m[3];
   assign max_all = (max_a > max_b) ? max_a : max_b;

   assign over_limit = LIM_W'(max_all) > LIMIT_V;

   assign item = {w[3], w[2], w[1], w[0], max_all, over_limit};

endmodule

// ----- hw/rtl/omx_queue.sv -----
// ----------------------------------------------------------------------------
// omx_queue
// Short queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module omx_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  omx_pkg::omx_item_type push_item,
   output logic                  can_push,
   input  logic                  pop,
   output omx_pkg::omx_item_type head,
   output logic                  head_valid
);
   import omx_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   omx_item_type     mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign can_push   = count_ff != FULL_CNT;
   assign head_valid = count_ff != '0;
   assign do_push    = push && can_push;
   assign do_pop     = pop && head_valid;
   assign head       = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hw/rtl/omx_back.sv -----
// ----------------------------------------------------------------------------
// omx_back
// Rescales a queued request that exceeds OUT_LIMIT with four restoring
// dividers and holds the response until it is taken.
// ----------------------------------------------------------------------------
module omx_back #(
   parameter int OUT_LIMIT = omx_pkg::OUT_LIMIT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  omx_pkg::omx_item_type             head,
   input  logic                              head_valid,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [omx_pkg::WHEELS-1:0][omx_pkg::WHEEL_W-1:0] wheels,
   output logic                              was_scaled
);
   import omx_pkg::*;

   localparam int LW    = $clog2(OUT_LIMIT + 1);
   localparam int QW    = $clog2(2 * OUT_LIMIT + 1);
   localparam int STEPS = (QW + DIV_BITS - 1) / DIV_BITS;
   localparam int QWP   = STEPS * DIV_BITS;
   localparam int NW    = SUM_W + LW;
   localparam int OW    = (QWP + 1 > WHEEL_W) ? QWP + 1 : WHEEL_W;
   localparam int CNT_W = $clog2(STEPS + 1);
   localparam logic [CNT_W-1:0] STEPS_V = CNT_W'(STEPS);

   omx_item_type     item_ff, item_in;
   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [QWP-1:0]   div_ff [WHEELS];
   logic [QWP-1:0]   div_in [WHEELS];
   logic [MAG_W-1:0] rem_ff [WHEELS];
   logic [MAG_W-1:0] rem_in [WHEELS];
   logic             rsp_valid_ff, rsp_valid_in;
   logic [WHEELS-1:0][WHEEL_W-1:0] wheels_ff, wheels_in;
   logic             scaled_ff, scaled_in;

   logic             done;
   logic             out_free;
   logic             out_load;
   logic [NW-1:0]    num [WHEELS];
   logic [OW-1:0]    shifted [WHEELS];

   assign done     = busy_ff && (cnt_ff == '0);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign out_load = done && out_free;
   assign pop      = head_valid && (!busy_ff || out_load);

   always_comb begin
      logic signed [SUM_W:0] offs;
      logic [MAG_W:0]        trial;
      logic [QWP-1:0]        d;
      logic [MAG_W-1:0]      r;
      for (int i = 0; i < WHEELS; i++) begin
         offs   = $signed({head.raw[i][SUM_W-1], head.raw[i]})
                + $signed({2'b00, head.mag});
         num[i] = NW'(offs[SUM_W-1:0]) * NW'(OUT_LIMIT);
         d = div_ff[i];
         r = rem_ff[i];
         for (int k = 0; k < DIV_BITS; k++) begin
            trial = {r, d[QWP-1]};
            d     = d << 1;
            if (trial >= {1'b0, item_ff.mag}) begin
               r    = MAG_W'(trial - {1'b0, item_ff.mag});
               d[0] = 1'b1;
            end else begin
               r = trial[MAG_W-1:0];
            end
         end
         div_in[i] = div_ff[i];
         rem_in[i] = rem_ff[i];
         if (busy_ff && cnt_ff != '0) begin
            div_in[i] = d;
            rem_in[i] = r;
         end
         if (pop) begin
            div_in[i] = num[i][QWP-1:0];
            rem_in[i] = MAG_W'(num[i] >> QWP);
         end
         shifted[i] = OW'(div_ff[i]) - OW'(OUT_LIMIT);
      end
   end

   always_comb begin
      item_in      = item_ff;
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      wheels_in    = wheels_ff;
      scaled_in    = scaled_ff;
      if (busy_ff && cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         scaled_in    = item_ff.scaled;
         busy_in      = 1'b0;
         for (int i = 0; i < WHEELS; i++) begin
            wheels_in[i] = item_ff.scaled ? shifted[i][WHEEL_W-1:0]
                                          : item_ff.raw[i][WHEEL_W-1:0];
         end
      end
      if (pop) begin
         item_in = head;
         busy_in = 1'b1;
         cnt_in  = head.scaled ? STEPS_V : '0;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      wheels_ff <= wheels_in;
      scaled_ff <= scaled_in;
      for (int i = 0; i < WHEELS; i++) begin
         div_ff[i] <= div_in[i];
         rem_ff[i] <= rem_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign wheels     = wheels_ff;
   assign was_scaled = scaled_ff;

   a_idle_no_count: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == '0)
      else $error("divider count running while idle");

   a_scaled_load: assert property (@(posedge clock) disable iff (reset)
      pop && head.scaled |=> busy_ff && cnt_ff == STEPS_V)
      else $error("scaled request did not start the divider");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      out_load && item_ff.scaled |->
         rem_ff[0] < item_ff.mag && rem_ff[1] < item_ff.mag &&
         rem_ff[2] < item_ff.mag && rem_ff[3] < item_ff.mag)
      else $error("divider remainder out of range");

endmodule

// ----- hw/rtl/four_wheel_omni_mixer.sv -----
// ----------------------------------------------------------------------------
// four_wheel_omni_mixer
// Mixes forward, sideways and rotation commands into four X-drive wheel values.
// ----------------------------------------------------------------------------
// Each request is mixed and classified in the cycle it is accepted and waits in
// a four-entry queue. A request whose largest wheel magnitude is within
// OUT_LIMIT passes through the back end without division. A request that must
// be rescaled holds the back end while the four restoring dividers retire
// three quotient bits per cycle. The response register lets the next request
// be divided while a finished response waits on rsp_tready.
// ----------------------------------------------------------------------------
module four_wheel_omni_mixer #(
   parameter int OUT_LIMIT = omx_pkg::OUT_LIMIT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // drive_forward [9:0], drive_sideways [19:10], drive_rotate [29:20]
   input  logic [omx_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // wheel_one [8:0], wheel_two [17:9], wheel_three [26:18], wheel_four [35:27]
   output logic [omx_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // was_scaled [0]
   output logic                            rsp_tuser
);
   import omx_pkg::*;

   omx_item_type front_item;
   omx_item_type head;
   logic         can_push;
   logic         head_valid;
   logic         pop;
   logic [WHEELS-1:0][WHEEL_W-1:0] wheels;

   omx_front #(.OUT_LIMIT(OUT_LIMIT)) u_front (
      .drive_forward  ($signed(req_tdata[DIN_W-1:0])),
      .drive_sideways ($signed(req_tdata[2*DIN_W-1:DIN_W])),
      .drive_rotate   ($signed(req_tdata[3*DIN_W-1:2*DIN_W])),
      .item           (front_item)
   );

   omx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid),
      .push_item  (front_item),
      .can_push   (can_push),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   omx_back #(.OUT_LIMIT(OUT_LIMIT)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .wheels     (wheels),
      .was_scaled (rsp_tuser)
   );

   assign req_tready = can_push;
   assign rsp_tdata  = {(RSP_DATA_W - WHEELS * WHEEL_W)'(0), wheels};

endmodule

// ----- test/wheel_mix_checker.sv -----
// ----------------------------------------------------------------------------
// wheel_mix_checker
// Watches both streams of the omni mixer, predicts each response from the
// accepted request and compares the wheel values and the scaled flag.
// ----------------------------------------------------------------------------
module wheel_mix_checker #(
   parameter int OUT_LIMIT = omx_pkg::OUT_LIMIT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // drive_forward [9:0], drive_sideways [19:10], drive_rotate [29:20]
   input  logic [omx_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // wheel_one [8:0], wheel_two [17:9], wheel_three [26:18], wheel_four [35:27]
   input  logic [omx_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // was_scaled [0]
   input  logic                           rsp_tuser,
   output int                             fail_count,
   output int                             pending_count
);
   import omx_pkg::*;

   typedef struct packed {
      logic [WHEEL_W-1:0] wheel_one;
      logic [WHEEL_W-1:0] wheel_two;
      logic [WHEEL_W-1:0] wheel_three;
      logic [WHEEL_W-1:0] wheel_four;
      logic               was_scaled;
   } wheel_set_type;

   wheel_set_type wheel_expect_q[$];
   wheel_set_type wheel_want;
   wheel_set_type wheel_got;
   int            mismatches = 0;

   function automatic wheel_set_type mix_wheels(input logic signed [DIN_W-1:0] fwd,
                                                input logic signed [DIN_W-1:0] side,
                                                input logic signed [DIN_W-1:0] rot);
      int            raw[4];
      int            peak;
      int            lim;
      int            mag;
      logic          scaled;
      wheel_set_type res;
      lim = OUT_LIMIT;
      raw[0] = int'(fwd) + int'(side) - int'(rot);
      raw[1] = int'(fwd) - int'(side) - int'(rot);
      raw[2] = -int'(fwd) - int'(side) - int'(rot);
      raw[3] = -int'(fwd) + int'(side) - int'(rot);
      peak = 0;
      for (int i = 0; i < 4; i++) begin
         mag = (raw[i] < 0) ? -raw[i] : raw[i];
         if (mag > peak) peak = mag;
      end
      scaled = (peak > lim);
      // The numerator is never negative, so integer division is a floor here.
      if (scaled) begin
         for (int i = 0; i < 4; i++) begin
            raw[i] = ((raw[i] + peak) * (2 * lim)) / (2 * peak) - lim;
         end
      end
      res.wheel_one   = raw[0][WHEEL_W-1:0];
      res.wheel_two   = raw[1][WHEEL_W-1:0];
      res.wheel_three = raw[2][WHEEL_W-1:0];
      res.wheel_four  = raw[3][WHEEL_W-1:0];
      res.was_scaled  = scaled;
      return res;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            wheel_got.wheel_one   = rsp_tdata[8:0];
            wheel_got.wheel_two   = rsp_tdata[17:9];
            wheel_got.wheel_three = rsp_tdata[26:18];
            wheel_got.wheel_four  = rsp_tdata[35:27];
            wheel_got.was_scaled  = rsp_tuser;
            if (wheel_expect_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 200)
                  $display("%0t: response with no request waiting, got %0d %0d %0d %0d %s %0d",
                           $time, $signed(wheel_got.wheel_one),
                           $signed(wheel_got.wheel_two),
                           $signed(wheel_got.wheel_three),
                           $signed(wheel_got.wheel_four), "scaled",
                           wheel_got.was_scaled);
            end else begin
               wheel_want = wheel_expect_q.pop_front();
               if (wheel_got !== wheel_want) begin
                  mismatches++;
                  if (mismatches <= 200)
                     $display("%0t: wheel mismatch, expected %0d %0d %0d %0d scaled %0d,%s",
                              $time, $signed(wheel_want.wheel_one),
                              $signed(wheel_want.wheel_two),
                              $signed(wheel_want.wheel_three),
                              $signed(wheel_want.wheel_four),
                              wheel_want.was_scaled,
                              $sformatf(" got %0d %0d %0d %0d scaled %0d",
                                        $signed(wheel_got.wheel_one),
                                        $signed(wheel_got.wheel_two),
                                        $signed(wheel_got.wheel_three),
                                        $signed(wheel_got.wheel_four),
                                        wheel_got.was_scaled));
               end
            end
         end
         if (req_tvalid && req_tready)
            wheel_expect_q.push_back(mix_wheels(req_tdata[9:0], req_tdata[19:10],
                                                req_tdata[29:20]));
      end
      pending_count <= wheel_expect_q.size();
      fail_count    <= mismatches;
   end

endmodule

// ----- test/four_wheel_omni_mixer_tb.sv -----
// ----------------------------------------------------------------------------
// four_wheel_omni_mixer_tb
// Drives directed and random drive commands into the omni mixer with random
// stalls on both streams and reports the checker's verdict.
// ----------------------------------------------------------------------------
module four_wheel_omni_mixer_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 1500;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [omx_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [omx_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;
   int                             fail_count;
   int                             pending_count;
   int                             idle_odds  = 0;
   int                             stall_left = 0;
   int                             cycle_count = 0;

   four_wheel_omni_mixer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   wheel_mix_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("four_wheel_omni_mixer verification failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_drive(input int fwd, input int side, input int rot);
      int                        gap;
      logic [omx_pkg::DIN_W-1:0] f;
      logic [omx_pkg::DIN_W-1:0] s;
      logic [omx_pkg::DIN_W-1:0] r;
      f = fwd[omx_pkg::DIN_W-1:0];
      s = side[omx_pkg::DIN_W-1:0];
      r = rot[omx_pkg::DIN_W-1:0];
      @(negedge clock);
      if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
         gap = $urandom_range(1, 3);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, r, s, f};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic int pick_axis(input int kind);
      int v;
      case (kind)
         0: begin
            v = $urandom_range(0, 170) - 85;
         end
         1: begin
            v = $urandom_range(0, 1023) - 512;
         end
         default: begin
            v = $urandom_range(248, 262);
            if ($urandom_range(0, 1) == 1) v = -v;
         end
      endcase
      return v;
   endfunction

   initial begin
      int kind;
      int lead;
      int axis[3];
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed commands: zero, single axes, limit edges and full range.
      send_drive(0, 0, 0);
      send_drive(1, 0, 0);
      send_drive(0, -1, 0);
      send_drive(0, 0, 1);
      send_drive(255, 0, 0);
      send_drive(0, -255, 0);
      send_drive(0, 0, 255);
      send_drive(128, 127, 0);
      send_drive(256, 0, 0);
      send_drive(-256, 0, 0);
      send_drive(0, 0, -256);
      send_drive(511, 0, 0);
      send_drive(-512, 0, 0);
      send_drive(0, 511, 0);
      send_drive(0, 0, -512);
      send_drive(511, 511, 511);
      send_drive(-512, -512, -512);
      send_drive(511, 511, -512);
      send_drive(-512, -512, 511);
      send_drive(511, -512, 511);
      send_drive(-512, 511, -512);
      send_drive(100, 100, 55);
      send_drive(-1, -1, -1);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n >= RANDOM_ITEMS - 200) begin
            idle_odds <= 0;
         end else if (n % 100 == 0) begin
            case ($urandom_range(0, 2))
               0: idle_odds <= 0;
               1: idle_odds <= 3;
               default: idle_odds <= 8;
            endcase
         end
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            for (int a = 0; a < 3; a++) axis[a] = pick_axis(0);
         end else if (kind < 8) begin
            for (int a = 0; a < 3; a++) axis[a] = pick_axis(1);
         end else begin
            lead = $urandom_range(0, 2);
            for (int a = 0; a < 3; a++) axis[a] = $urandom_range(0, 6) - 3;
            axis[lead] = pick_axis(2);
         end
         send_drive(axis[0], axis[1], axis[2]);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("four_wheel_omni_mixer verification clean");
      end else begin
         $display("four_wheel_omni_mixer verification failed");
      end
      $finish;
   end

endmodule
